// ===== hdl/biqt_pkg.sv =====
// ----------------------------------------------------------------------------
// biqt_pkg
// Shared types and constants for the binary image quadtree builder.
// ----------------------------------------------------------------------------
package biqt_pkg;

    localparam int CFG_W  = 4;
    localparam int COLOR_W = 2;
    localparam int KIDS_W = 4 * COLOR_W;
    localparam int COORD_W = 8;
    localparam int SIDE_W = 9;

    localparam logic [CFG_W-1:0] SIDE_LOG2_RST = 4'd8;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_MIXED = 2'd2;
    localparam logic [COLOR_W-1:0] NO_KID      = 2'd3;

    localparam logic [1:0] POS_SE = 2'd3;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [KIDS_W-1:0]  kids_t;

    // node token travelling along the cell chain
    typedef struct packed {
        logic   valid;
        color_t color;
        kids_t  kids;
        logic   has_kids;
    } tok_t;

endpackage

// ===== hdl/biqt_ifs.sv =====
// ----------------------------------------------------------------------------
// biqt_ifs
// Valid/ready channels: pixel words in, node record words out.
// ----------------------------------------------------------------------------
interface biqt_pixel_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface biqt_node_if;
    logic                          valid;
    logic                          ready;
    logic [biqt_pkg::COLOR_W-1:0]  node_color;
    logic [biqt_pkg::COORD_W-1:0]  upper_row;
    logic [biqt_pkg::COORD_W-1:0]  upper_col;
    logic [biqt_pkg::SIDE_W-1:0]   node_side;
    logic [biqt_pkg::COLOR_W-1:0]  nw_kid;
    logic [biqt_pkg::COLOR_W-1:0]  ne_kid;
    logic [biqt_pkg::COLOR_W-1:0]  sw_kid;
    logic [biqt_pkg::COLOR_W-1:0]  se_kid;
    logic                          last_of_run;
    logic                          root_done;

    modport source (output valid, output node_color, output upper_row, output upper_col,
                    output node_side, output nw_kid, output ne_kid, output sw_kid,
                    output se_kid, output last_of_run, output root_done, input ready);
    modport sink   (input valid, input node_color, input upper_row, input upper_col,
                    input node_side, input nw_kid, input ne_kid, input sw_kid,
                    input se_kid, input last_of_run, input root_done, output ready);
endinterface

// ===== hdl/binary_image_quadtree_builder.sv =====
// ----------------------------------------------------------------------------
// binary_image_quadtree_builder
// Region quadtree over a square binary image fed in quadrant order; emits
// each leaf and every completed parent in post-order.
//
//   channel   dir  handshake      word
//   pixels    in   valid/ready    pixel
//   nodes     out  valid/ready    node record
//   cfg       in   cfg_wr_en      side_log2
//
// A pixel yields R = 1 .. n+1 records; the token walks the level-cell
// chain one cell, one record, per cycle while the output is not stalled.
// The next pixel is taken once the last record of the run is registered.
// A stalled output holds the token in its cell.
// Reset: control only, no clearing pass; kid stores fill before use.
// ----------------------------------------------------------------------------
module binary_image_quadtree_builder #(
    parameter int MAX_SIDE_LOG2 = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [biqt_pkg::CFG_W-1:0] cfg_wr_data,
    biqt_pixel_if.sink                 pixels,
    biqt_node_if.source                nodes
);
    import biqt_pkg::*;

    localparam int LVL_W = $clog2(MAX_SIDE_LOG2 + 1);
    localparam int IDX_W = 2 * MAX_SIDE_LOG2;

    logic [CFG_W-1:0]         side_log2_reg;
    logic [IDX_W-1:0]         pixel_count_reg;
    logic [IDX_W-1:0]         pixel_count_next;
    logic [LVL_W-1:0]         level_reg;
    logic [LVL_W-1:0]         level_next;
    logic [LVL_W-1:0]         n_eff;
    logic [IDX_W-1:0]         mask;
    logic [IDX_W-1:0]         idx;
    logic [MAX_SIDE_LOG2-1:0] row_full;
    logic [MAX_SIDE_LOG2-1:0] col_full;

    tok_t                     chain [0:MAX_SIDE_LOG2+1];
    tok_t                     recs  [0:MAX_SIDE_LOG2];
    tok_t                     sel;
    logic                     handoff_any;
    logic                     busy;
    logic                     out_free;
    logic                     emit;
    logic                     accept;

    logic                     out_valid_reg;
    color_t                   color_reg;
    logic [COORD_W-1:0]       row_reg;
    logic [COORD_W-1:0]       col_reg;
    logic [SIDE_W-1:0]        side_reg;
    kids_t                    kids_reg;
    logic                     last_reg;
    logic                     root_reg;

    always_comb
    begin
        if (int'(side_log2_reg) > MAX_SIDE_LOG2)
        begin
            n_eff = LVL_W'(MAX_SIDE_LOG2);
        end
        else
        begin
            n_eff = LVL_W'(side_log2_reg);
        end
        for (int i = 0; i < IDX_W; i++)
        begin
            mask[i] = (i < 2 * int'(n_eff));
        end
        idx = pixel_count_reg & mask;
        for (int i = 0; i < MAX_SIDE_LOG2; i++)
        begin
            col_full[i] = (i >= int'(level_reg)) ? idx[2*i]   : 1'b0;
            row_full[i] = (i >= int'(level_reg)) ? idx[2*i+1] : 1'b0;
        end
    end

    assign chain[0].valid    = accept;
    assign chain[0].color    = {1'b0, pixels.pixel};
    assign chain[0].kids     = '0;
    assign chain[0].has_kids = 1'b0;

    for (genvar l = 0; l <= MAX_SIDE_LOG2; l++)
    begin : g_cell
        logic [1:0] pos;
        if (l < MAX_SIDE_LOG2)
        begin : g_pos
            assign pos = idx[2*l+1:2*l];
        end
        else
        begin : g_top
            assign pos = 2'b00;
        end
        biqt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (out_free),
            .last    (n_eff == LVL_W'(l)),
            .pos     (pos),
            .tok_in  (chain[l]),
            .tok_out (chain[l+1]),
            .rec     (recs[l])
        );
    end

    always_comb
    begin
        sel = '0;
        handoff_any = 1'b0;
        for (int l = 0; l <= MAX_SIDE_LOG2; l++)
        begin
            if (recs[l].valid)
            begin
                sel = sel | recs[l];
            end
            handoff_any = handoff_any | chain[l+1].valid;
        end
        busy     = sel.valid;
        out_free = !out_valid_reg || nodes.ready;
        emit     = busy && out_free;
        accept   = pixels.valid && !busy;

        level_next = level_reg;
        if (accept)
        begin
            level_next = '0;
        end
        else if (emit && handoff_any)
        begin
            level_next = level_reg + LVL_W'(1);
        end

        pixel_count_next = pixel_count_reg;
        if (cfg_wr_en)
        begin
            pixel_count_next = '0;
        end
        else if (emit && !handoff_any)
        begin
            pixel_count_next = (idx + IDX_W'(1)) & mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg   <= SIDE_LOG2_RST;
            pixel_count_reg <= '0;
            level_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_log2_reg <= cfg_wr_data;
            end
            pixel_count_reg <= pixel_count_next;
            level_reg       <= level_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            color_reg <= sel.color;
            row_reg   <= COORD_W'(row_full);
            col_reg   <= COORD_W'(col_full);
            side_reg  <= SIDE_W'(1) << level_reg;
            kids_reg  <= sel.has_kids ? sel.kids : {4{NO_KID}};
            last_reg  <= !handoff_any;
            root_reg  <= (level_reg == n_eff);
        end
    end

    assign pixels.ready      = !busy;
    assign nodes.valid       = out_valid_reg;
    assign nodes.node_color  = color_reg;
    assign nodes.upper_row   = row_reg;
    assign nodes.upper_col   = col_reg;
    assign nodes.node_side   = side_reg;
    assign nodes.nw_kid      = kids_reg[1:0];
    assign nodes.ne_kid      = kids_reg[3:2];
    assign nodes.sw_kid      = kids_reg[5:4];
    assign nodes.se_kid      = kids_reg[7:6];
    assign nodes.last_of_run = last_reg;
    assign nodes.root_done   = root_reg;

endmodule

// ===== hdl/biqt_cell.sv =====
// ----------------------------------------------------------------------------
// biqt_cell
// One tree level: holds the node token at this level and the kid colors
// gathered so far; hands the parent token on when the fourth kid lands.
// ----------------------------------------------------------------------------
module biqt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          last,
    input  logic [1:0]    pos,
    input  biqt_pkg::tok_t tok_in,
    output biqt_pkg::tok_t tok_out,
    output biqt_pkg::tok_t rec
);
    import biqt_pkg::*;

    tok_t   tok_reg;
    tok_t   tok_next;
    kids_t  kids_reg;
    kids_t  kids_next;
    kids_t  kids_new;
    logic   fire;
    logic   wr;
    color_t k0;
    color_t k1;
    color_t k2;
    color_t k3;

    always_comb
    begin
        kids_new = kids_reg;
        kids_new[{pos, 1'b0} +: COLOR_W] = tok_reg.color;
        fire = tok_reg.valid && step;
        wr   = fire && !last;
        k0 = kids_new[1:0];
        k1 = kids_new[3:2];
        k2 = kids_new[5:4];
        k3 = kids_new[7:6];

        kids_next = wr ? kids_new : kids_reg;

        tok_out.valid = wr && (pos == POS_SE);
        tok_out.kids  = kids_new;
        if (k0 == k1 && k1 == k2 && k2 == k3 && k0 != COLOR_MIXED)
        begin
            tok_out.color    = k0;
            tok_out.has_kids = 1'b0;
        end
        else
        begin
            tok_out.color    = COLOR_MIXED;
            tok_out.has_kids = 1'b1;
        end

        tok_next = tok_reg;
        if (tok_in.valid)
        begin
            tok_next = tok_in;
        end
        else if (fire)
        begin
            tok_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kids_reg <= kids_next;
    end

    assign rec = tok_reg;

endmodule

// ===== hdl/biqt_checker.sv =====
// ----------------------------------------------------------------------------
// biqt_checker
// Port-level checks on the quadtree builder, bound to the top level.
// ----------------------------------------------------------------------------
module biqt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [biqt_pkg::COLOR_W-1:0] node_color,
    input logic [biqt_pkg::COLOR_W-1:0] nw_kid,
    input logic [biqt_pkg::COLOR_W-1:0] ne_kid,
    input logic [biqt_pkg::COLOR_W-1:0] sw_kid,
    input logic [biqt_pkg::COLOR_W-1:0] se_kid,
    input logic                         last_of_run,
    input logic                         root_done
);
    import biqt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("node word dropped while stalled");

    a_root_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_done |-> last_of_run)
        else $error("root record not last of run");

    a_mixed_kids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && node_color == COLOR_MIXED |->
            nw_kid != NO_KID && ne_kid != NO_KID && sw_kid != NO_KID && se_kid != NO_KID)
        else $error("mixed node without kids");

    a_solid_nokids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && node_color != COLOR_MIXED |->
            nw_kid == NO_KID && ne_kid == NO_KID && sw_kid == NO_KID && se_kid == NO_KID)
        else $error("solid node reports kids");

    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second pixel taken during a run");

endmodule

bind binary_image_quadtree_builder biqt_checker u_biqt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pixels.valid),
    .in_ready    (pixels.ready),
    .out_valid   (nodes.valid),
    .out_ready   (nodes.ready),
    .node_color  (nodes.node_color),
    .nw_kid      (nodes.nw_kid),
    .ne_kid      (nodes.ne_kid),
    .sw_kid      (nodes.sw_kid),
    .se_kid      (nodes.se_kid),
    .last_of_run (nodes.last_of_run),
    .root_done   (nodes.root_done)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary image quadtree builder. Pixel words are
// driven in quadrant order over several image sizes. A scoreboard works out
// the leaf and post-order parent records of each pixel and checks every node
// word, field by field, against them. Both channels idle at random, and the
// output is held off long enough to back up the pixel channel.
// ----------------------------------------------------------------------------
module testbench;
    import biqt_pkg::*;

    localparam int MAX_LOG2   = 8;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_RARE  = 6;
    localparam int IDLE_OFTEN = 88;
    localparam int NO_PAUSE   = -1;

    typedef enum int unsigned {FILL_WHITE, FILL_BLACK, FILL_NOISE} fill_t;

    typedef struct packed {
        color_t             color;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SIDE_W-1:0]  side;
        color_t             nw;
        color_t             ne;
        color_t             sw;
        color_t             se;
        logic               last;
        logic               root;
    } node_word_t;

    class quadtree_scoreboard;
        logic [CFG_W-1:0] side_log2;
        int unsigned      next_index;
        kids_t            level_kids [MAX_LOG2];
        node_word_t       awaited [$];
        int unsigned      errors;
        int unsigned      pixels_seen;
        int unsigned      nodes_seen;
        int unsigned      roots_seen;
        int unsigned      collapsed_seen;
        int unsigned      mixed_seen;

        function new();
            side_log2      = SIDE_LOG2_RST;
            next_index     = 0;
            errors         = 0;
            pixels_seen    = 0;
            nodes_seen     = 0;
            roots_seen     = 0;
            collapsed_seen = 0;
            mixed_seen     = 0;
            foreach (level_kids[i])
                level_kids[i] = '0;
        endfunction

        function void set_side(logic [CFG_W-1:0] v);
            side_log2  = v;
            next_index = 0;
        endfunction

        function node_word_t make_word(color_t c, int unsigned idx, int unsigned side,
                                       kids_t kids, logic has_kids);
            node_word_t w;
            w.row = '0;
            w.col = '0;
            // quadrant index interleaves column (even bits) and row (odd bits)
            for (int i = 0; i < COORD_W; i++)
            begin
                w.col[i] = 1'((idx >> (2 * i)) & 1);
                w.row[i] = 1'((idx >> (2 * i + 1)) & 1);
            end
            w.color = c;
            w.side  = side[SIDE_W-1:0];
            w.nw    = has_kids ? kids[1:0] : NO_KID;
            w.ne    = has_kids ? kids[3:2] : NO_KID;
            w.sw    = has_kids ? kids[5:4] : NO_KID;
            w.se    = has_kids ? kids[7:6] : NO_KID;
            w.last  = 1'b0;
            w.root  = 1'b0;
            return w;
        endfunction

        function void note_pixel(logic p);
            int unsigned n;
            int unsigned total_mask;
            int unsigned idx;
            int unsigned grp;
            kids_t       kids;
            color_t      pcol;
            color_t      leaf;
            logic        has_kids;
            node_word_t  w;
            node_word_t  run [$];
            pixels_seen++;
            n          = (side_log2 > MAX_LOG2) ? MAX_LOG2 : side_log2;
            total_mask = (1 << (2 * n)) - 1;
            idx        = next_index & total_mask;
            leaf       = p ? COLOR_BLACK : COLOR_WHITE;
            run.push_back(make_word(leaf, idx, 1, '0, 1'b0));
            if (n == 0)
            begin
                run[0].root = 1'b1;
            end
            else
            begin
                level_kids[0][2 * (idx & 3) +: 2] = leaf;
                for (int l = 0; l < n; l++)
                begin
                    grp = (1 << (2 * (l + 1))) - 1;
                    if ((idx & grp) != grp)
                        break;
                    kids = level_kids[l];
                    if (kids[1:0] == kids[3:2] && kids[3:2] == kids[5:4] &&
                        kids[5:4] == kids[7:6] && kids[1:0] != COLOR_MIXED)
                    begin
                        pcol     = kids[1:0];
                        has_kids = 1'b0;
                        collapsed_seen++;
                    end
                    else
                    begin
                        pcol     = COLOR_MIXED;
                        has_kids = 1'b1;
                        mixed_seen++;
                    end
                    w      = make_word(pcol, idx & ~grp, 1 << (l + 1), kids, has_kids);
                    w.root = (l + 1 == n);
                    run.push_back(w);
                    if (!w.root)
                        level_kids[l + 1][2 * ((idx >> (2 * (l + 1))) & 3) +: 2] = pcol;
                end
            end
            run[run.size() - 1].last = 1'b1;
            if (run[run.size() - 1].root)
            begin
                next_index = 0;
                roots_seen++;
            end
            else
            begin
                next_index = (idx + 1) & total_mask;
            end
            foreach (run[i])
                awaited.push_back(run[i]);
        endfunction

        function void compare_field(string name, logic [SIDE_W-1:0] want,
                                    logic [SIDE_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_node(node_word_t got);
            node_word_t want;
            nodes_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected node word, expected none, got %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("node_color",  SIDE_W'(want.color), SIDE_W'(got.color));
            compare_field("upper_row",   SIDE_W'(want.row),   SIDE_W'(got.row));
            compare_field("upper_col",   SIDE_W'(want.col),   SIDE_W'(got.col));
            compare_field("node_side",   want.side,           got.side);
            compare_field("nw_kid",      SIDE_W'(want.nw),    SIDE_W'(got.nw));
            compare_field("ne_kid",      SIDE_W'(want.ne),    SIDE_W'(got.ne));
            compare_field("sw_kid",      SIDE_W'(want.sw),    SIDE_W'(got.sw));
            compare_field("se_kid",      SIDE_W'(want.se),    SIDE_W'(got.se));
            compare_field("last_of_run", SIDE_W'(want.last),  SIDE_W'(got.last));
            compare_field("root_done",   SIDE_W'(want.root),  SIDE_W'(got.root));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               sink_idle_pct = IDLE_OFTEN;
    int               hold_left = 0;

    quadtree_scoreboard sb = new();

    biqt_pixel_if pixels_ch ();
    biqt_node_if  nodes_ch ();

    binary_image_quadtree_builder #(
        .MAX_SIDE_LOG2(MAX_LOG2)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pixels     (pixels_ch),
        .nodes      (nodes_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // node word receiver; long hold-offs are counted here
    initial
    begin
        nodes_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && nodes_ch.valid && nodes_ch.ready)
                sb.check_node('{color: nodes_ch.node_color, row: nodes_ch.upper_row,
                                col: nodes_ch.upper_col, side: nodes_ch.node_side,
                                nw: nodes_ch.nw_kid, ne: nodes_ch.ne_kid,
                                sw: nodes_ch.sw_kid, se: nodes_ch.se_kid,
                                last: nodes_ch.last_of_run, root: nodes_ch.root_done});
            if (hold_left > 0)
            begin
                hold_left--;
                nodes_ch.ready <= 1'b0;
            end
            else
            begin
                nodes_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_pixel(logic p, int src_idle);
        while ($urandom_range(99) < src_idle)
        begin
            pixels_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixels_ch.valid <= 1'b1;
        pixels_ch.pixel <= p;
        @(posedge clk);
        while (!pixels_ch.ready)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic stop_and_drain();
        pixels_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited.size() != 0);
    endtask

    task automatic write_side(logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_side(v);
    endtask

    task automatic run_directed(bit write_cfg, logic [CFG_W-1:0] side,
                                logic [31:0] bits, int count, int src_idle);
        if (write_cfg)
            write_side(side);
        for (int i = 0; i < count; i++)
            send_pixel(bits[i], src_idle);
        stop_and_drain();
    endtask

    // random images built from aligned solid blocks and noise
    task automatic run_random(logic [CFG_W-1:0] side, int count, int src_idle,
                              int pause_at, int hold_at);
        int unsigned n;
        int unsigned e;
        int unsigned blk_left;
        fill_t       fill;
        logic        p;
        write_side(side);
        n        = (side > MAX_LOG2) ? MAX_LOG2 : side;
        blk_left = 0;
        fill     = FILL_NOISE;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                stop_and_drain();
            if (i == hold_at)
                hold_left = LONG_HOLD;
            if (blk_left == 0)
            begin
                e = $urandom_range(3, 0);
                if (e > n)
                    e = n;
                while (e > 0 && (i % (1 << (2 * e))) != 0)
                    e--;
                blk_left = 1 << (2 * e);
                fill     = fill_t'($urandom_range(2, 0));
            end
            blk_left--;
            case (fill)
                FILL_WHITE: p = 1'b0;
                FILL_BLACK: p = 1'b1;
                default:    p = 1'($urandom_range(1, 0));
            endcase
            send_pixel(p, src_idle);
        end
        stop_and_drain();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        pixels_ch.valid <= 1'b0;
        pixels_ch.pixel <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idle, receiver mostly stalled
        sink_idle_pct = IDLE_OFTEN;
        run_directed(1'b0, SIDE_LOG2_RST, 32'b1111_0000, 8, IDLE_RARE);
        run_directed(1'b1, 4'd0, 32'b10, 2, IDLE_RARE);
        run_directed(1'b1, 4'd1, 32'b0111_1010_0000_1111, 16, IDLE_RARE);
        run_random(4'd2, 48, IDLE_RARE, NO_PAUSE, NO_PAUSE);
        run_random(4'd15, 32, IDLE_RARE, NO_PAUSE, NO_PAUSE);

        // sender mostly idle, receiver rarely stalled
        sink_idle_pct = IDLE_RARE;
        run_random(4'd3, 64, IDLE_OFTEN, 32, NO_PAUSE);
        run_random(4'd0, 10, IDLE_OFTEN, NO_PAUSE, NO_PAUSE);

        // full rate, with one long output hold-off
        sink_idle_pct = 0;
        run_random(4'd1, 40, 0, NO_PAUSE, 5);
        run_random(4'd4, 64, 0, NO_PAUSE, NO_PAUSE);

        repeat (20) @(posedge clk);
        $display("summary: %0d pixel words over sizes 1x1 to 256x256, %0d node words checked",
                 sb.pixels_seen, sb.nodes_seen);
        $display("summary: %0d roots, %0d collapsed and %0d mixed parents, %0d mismatches",
                 sb.roots_seen, sb.collapsed_seen, sb.mixed_seen, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
